### rtl/steering_zero_offset_calibrator_defines.svh
// Assertion macros for the steering zero-offset calibrator.
`ifndef STEERING_ZERO_OFFSET_CALIBRATOR_DEFINES_SVH
`define STEERING_ZERO_OFFSET_CALIBRATOR_DEFINES_SVH
`ifndef SYNTH
`define SZOC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SZOC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SZOC_ASSERT_IMPL(name, ante, cons, msg)
`define SZOC_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### rtl/szoc_pkg.sv
// Package with widths, constants and register codes of the steering zero-offset calibrator.
`timescale 1ns / 1ps
`default_nettype none

package szoc_pkg;

  localparam int WINDOW_DEFAULT = 100;

  localparam int SPEED_W  = 16;
  localparam int HRAD_W   = 20;
  localparam int STEER_W  = 19;
  localparam int OFFSET_W = 21;
  localparam int HDEG_W   = 20;

  localparam int MIN_SPEED_W = 15;
  localparam int HSPREAD_W   = 16;
  localparam int SSPREAD_W   = 16;
  localparam int OLIMIT_W    = 20;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [MIN_SPEED_W-1:0] MIN_SPEED_RST = 15'd2560;
  localparam logic [HSPREAD_W-1:0]   HSPREAD_RST   = 16'd205;
  localparam logic [SSPREAD_W-1:0]   SSPREAD_RST   = 16'd256;
  localparam logic [OLIMIT_W-1:0]    OLIMIT_RST    = 20'd393216;

  localparam int HPROD_W = 37;
  localparam logic signed [17:0]        HDEG_MUL = 18'sd58671;
  localparam logic signed [HPROD_W-1:0] HDEG_RND = 37'sd32768;
  localparam int HDEG_SHIFT = 16;

  localparam int QUOT_W = 18;
  localparam int FRAC_W = 9;
  localparam int MEAN_W = QUOT_W + 1 + FRAC_W;

  localparam int P999_W = 31;
  localparam int NUM_W  = 33;
  localparam int BU_W   = 31;
  localparam int BQ_W   = 22;
  localparam int BPROD_W = BU_W + 32;
  localparam int BLEND_SHIFT = 41;
  localparam logic signed [10:0]      BLEND_OLD   = 11'sd999;
  localparam logic signed [NUM_W-1:0] BLEND_BIAS  = 33'sd1048576500;
  localparam logic [31:0]             BLEND_RECIP = 32'd2199023255;
  localparam logic [9:0]              BLEND_DEN   = 10'd1000;
  localparam logic [BQ_W-1:0]         BLEND_OFS   = 22'd1048576;

  localparam int STAGES = 13;

  typedef enum logic [1:0] {
    REG_MIN_SPEED,
    REG_HEADING_SPREAD,
    REG_STEER_SPREAD,
    REG_OFFSET_LIMIT
  } reg_idx_t;

endpackage

`default_nettype wire

### rtl/steering_zero_offset_calibrator.sv
// Top level of the steering zero-offset calibrator.
// The block takes one sample item per clock cycle unless the result side stalls, and
// delivers one result item per sample. The block is a 13-stage pipeline: heading
// scaling, window statistics, and two divisions by constants (window mean and blend)
// done as a reciprocal multiply, a back-multiply and a remainder correction, each
// multiply followed by a register. Windows are WINDOW samples long and start at
// reset. Configuration sits on a small APB port at byte addresses 0, 4, 8 and 12.
`timescale 1ns / 1ps
`default_nettype none
`include "steering_zero_offset_calibrator_defines.svh"

module steering_zero_offset_calibrator #(
  parameter int WINDOW = szoc_pkg::WINDOW_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [szoc_pkg::ADDR_W-1:0]          paddr,
  input  logic [szoc_pkg::DATA_W-1:0]          pwdata,
  output logic [szoc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [szoc_pkg::SPEED_W-1:0]  vehicle_speed,
  input  logic signed [szoc_pkg::HRAD_W-1:0]   heading_rad,
  input  logic signed [szoc_pkg::STEER_W-1:0]  steer_angle,
  input  logic signed [szoc_pkg::OFFSET_W-1:0] prior_offset,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 offset_valid,
  output logic signed [szoc_pkg::OFFSET_W-1:0] new_offset
);
  import szoc_pkg::*;

  localparam int DIV_WIN = 2 * WINDOW;
  localparam int DW = $clog2(DIV_WIN);
  localparam int UW = DW + STEER_W - 1;
  localparam int CW = $clog2(WINDOW);
  localparam logic [DW:0]       DIV_WIN_V = (DW + 1)'(DIV_WIN);
  localparam logic [31:0]       RECIP_WIN = 32'((64'd1 << 32) / DIV_WIN);
  localparam logic [UW-1:0]     BIAS_WIN  = UW'(DIV_WIN * (2 ** (STEER_W - 2)));
  localparam logic [QUOT_W:0]   QUOT_OFS  = (QUOT_W + 1)'(2 ** (STEER_W - 2));
  localparam logic [CW-1:0]     LAST_CNT  = CW'(WINDOW - 1);

  // Configuration registers.
  logic [MIN_SPEED_W-1:0] min_speed;
  logic [HSPREAD_W-1:0]   heading_spread_limit;
  logic [SSPREAD_W-1:0]   steer_spread_limit;
  logic [OLIMIT_W-1:0]    offset_limit;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed            <= MIN_SPEED_RST;
      heading_spread_limit <= HSPREAD_RST;
      steer_spread_limit   <= SSPREAD_RST;
      offset_limit         <= OLIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_SPEED:      min_speed            <= pwdata[MIN_SPEED_W-1:0];
        REG_HEADING_SPREAD: heading_spread_limit <= pwdata[HSPREAD_W-1:0];
        REG_STEER_SPREAD:   steer_spread_limit   <= pwdata[SSPREAD_W-1:0];
        REG_OFFSET_LIMIT:   offset_limit         <= pwdata[OLIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_SPEED:      prdata = DATA_W'(min_speed);
      REG_HEADING_SPREAD: prdata = DATA_W'(heading_spread_limit);
      REG_STEER_SPREAD:   prdata = DATA_W'(steer_spread_limit);
      REG_OFFSET_LIMIT:   prdata = DATA_W'(offset_limit);
    endcase
  end

  // Pipeline control: every stage moves together when the output register can move.
  logic [STAGES-1:0] stage_vld;
  logic              adv;

  assign adv          = !stage_vld[STAGES-1] || result_ready;
  assign sample_ready = adv;
  assign result_valid = stage_vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else if (adv) begin
      stage_vld <= {stage_vld[STAGES-2:0], sample_valid};
    end
  end

  // Stage registers.
  logic signed [SPEED_W-1:0]  s1_speed, s2_speed, s3_speed, s4_speed;
  logic signed [HRAD_W-1:0]   s1_hrad;
  logic signed [STEER_W-1:0]  s1_steer, s2_steer, s3_steer;
  logic signed [OFFSET_W-1:0] s1_prior, s2_prior, s3_prior, s4_prior, s5_prior, s6_prior;
  logic signed [OFFSET_W-1:0] s7_prior, s8_prior, s9_prior, s10_prior, s11_prior, s12_prior;
  logic signed [HPROD_W-1:0]  s2_hprod;
  logic signed [HDEG_W-1:0]   s3_hdeg;
  logic                       s4_end;
  logic signed [UW-1:0]       s4_sum;
  logic signed [HDEG_W-1:0]   s4_hmax, s4_hmin;
  logic signed [STEER_W-1:0]  s4_smax, s4_smin;
  logic                       s5_cand, s6_cand, s7_cand, s8_cand, s9_cand;
  logic [UW-1:0]              s5_u, s6_u, s7_u;
  logic [UW+31:0]             s6_prod;
  logic [QUOT_W-1:0]          s7_qest, s8_q;
  logic [UW-1:0]              s7_qd;
  logic [DW-1:0]              s8_r;
  logic signed [MEAN_W-1:0]   s9_mean;
  logic signed [P999_W-1:0]   s9_p999;
  logic                       s10_ok, s11_ok, s12_ok;
  logic [BU_W-1:0]            s10_u2, s11_u2, s12_u2;
  logic [BPROD_W-1:0]         s11_prod;
  logic [BQ_W-1:0]            s12_q2e;
  logic [31:0]                s12_qk;

  // Window state.
  logic [CW-1:0]              count, count_next;
  logic signed [UW-1:0]       sum, sum_next, sum_base, steer_ext;
  logic signed [HDEG_W-1:0]   hmax, hmin, hmax_next, hmin_next;
  logic signed [STEER_W-1:0]  smax, smin, smax_next, smin_next;
  logic                       win_start, win_end;

  assign win_start = (count == '0);
  assign win_end   = (count == LAST_CNT);
  assign hmax_next = (win_start || (s3_hdeg > hmax)) ? s3_hdeg : hmax;
  assign hmin_next = (win_start || (s3_hdeg < hmin)) ? s3_hdeg : hmin;
  assign smax_next = (win_start || (s3_steer > smax)) ? s3_steer : smax;
  assign smin_next = (win_start || (s3_steer < smin)) ? s3_steer : smin;
  assign steer_ext = {{(UW - STEER_W){s3_steer[STEER_W-1]}}, s3_steer};
  assign sum_base  = win_start ? {UW{1'b0}} : sum;
  assign sum_next  = sum_base + steer_ext;
  assign count_next = win_end ? {CW{1'b0}} : count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      hmax  <= '0;
      hmin  <= '0;
      smax  <= '0;
      smin  <= '0;
    end else if (adv && stage_vld[2]) begin
      count <= count_next;
      sum   <= sum_next;
      hmax  <= hmax_next;
      hmin  <= hmin_next;
      smax  <= smax_next;
      smin  <= smin_next;
    end
  end

  // Combinational logic between stages.
  logic signed [HPROD_W-1:0]  hprod_c, hsum_c;
  logic                       speed_ok, h_ok, s_ok;
  logic [HDEG_W:0]            hspread;
  logic [STEER_W:0]           sspread;
  logic [UW+31:0]             prod1_c;
  logic [QUOT_W-1:0]          qest_c;
  logic [UW-1:0]              qd_c, rem_full;
  logic [DW:0]                rem_c, rem_adj;
  logic                       rem_fix;
  logic [FRAC_W-1:0]          frac_rom [DIV_WIN];
  logic [FRAC_W-1:0]          frac_c;
  logic [QUOT_W:0]            quot_ofs;
  logic signed [MEAN_W-1:0]   mean_c, lim_pos, lim_neg;
  logic signed [P999_W-1:0]   p999_c;
  logic                       in_lim;
  logic signed [NUM_W-1:0]    num_c;
  logic [BPROD_W-1:0]         prod2_c;
  logic [BQ_W-1:0]            q2e_c, q2_c, blend_c;
  logic [31:0]                qk_c, rem2_full;
  logic                       rem2_fix;

  assign hprod_c = s1_hrad * HDEG_MUL;
  assign hsum_c  = s2_hprod + HDEG_RND;

  assign speed_ok = s4_speed > $signed({1'b0, min_speed});
  assign hspread  = {s4_hmax[HDEG_W-1], s4_hmax} - {s4_hmin[HDEG_W-1], s4_hmin};
  assign sspread  = {s4_smax[STEER_W-1], s4_smax} - {s4_smin[STEER_W-1], s4_smin};
  assign h_ok     = hspread < (HDEG_W + 1)'(heading_spread_limit);
  assign s_ok     = sspread < (STEER_W + 1)'(steer_spread_limit);

  assign prod1_c  = s5_u * RECIP_WIN;
  assign qest_c   = s6_prod[32 +: QUOT_W];
  assign qd_c     = qest_c * DIV_WIN_V;
  assign rem_full = s7_u - s7_qd;
  assign rem_c    = rem_full[DW:0];
  assign rem_fix  = rem_c >= DIV_WIN_V;
  assign rem_adj  = rem_c - DIV_WIN_V;

  for (genvar i = 0; i < DIV_WIN; i++) begin : g_frac
    localparam int FracVal = (i * 512 + WINDOW) / DIV_WIN;
    assign frac_rom[i] = FRAC_W'(FracVal);
  end

  assign frac_c   = frac_rom[s8_r];
  assign quot_ofs = {1'b0, s8_q} - QUOT_OFS;
  assign mean_c   = $signed({quot_ofs, frac_c});
  assign p999_c   = s8_prior * BLEND_OLD;

  assign lim_pos = $signed(MEAN_W'(offset_limit));
  assign lim_neg = -lim_pos;
  assign in_lim  = (s9_mean <= lim_pos) && (s9_mean >= lim_neg);
  assign num_c   = s9_mean + s9_p999 + BLEND_BIAS;

  assign prod2_c   = s10_u2 * BLEND_RECIP;
  assign q2e_c     = s11_prod[BLEND_SHIFT +: BQ_W];
  assign qk_c      = q2e_c * BLEND_DEN;
  assign rem2_full = {1'b0, s12_u2} - s12_qk;
  assign rem2_fix  = rem2_full >= 32'(BLEND_DEN);
  assign q2_c      = s12_q2e + BQ_W'(rem2_fix);
  assign blend_c   = q2_c - BLEND_OFS;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_speed  <= vehicle_speed;
      s1_hrad   <= heading_rad;
      s1_steer  <= steer_angle;
      s1_prior  <= prior_offset;

      s2_hprod  <= hprod_c;
      s2_speed  <= s1_speed;
      s2_steer  <= s1_steer;
      s2_prior  <= s1_prior;

      s3_hdeg   <= hsum_c[HDEG_SHIFT +: HDEG_W];
      s3_speed  <= s2_speed;
      s3_steer  <= s2_steer;
      s3_prior  <= s2_prior;

      s4_end    <= win_end;
      s4_sum    <= sum_next;
      s4_hmax   <= hmax_next;
      s4_hmin   <= hmin_next;
      s4_smax   <= smax_next;
      s4_smin   <= smin_next;
      s4_speed  <= s3_speed;
      s4_prior  <= s3_prior;

      s5_cand   <= s4_end && speed_ok && h_ok && s_ok;
      s5_u      <= UW'($unsigned(s4_sum)) + BIAS_WIN;
      s5_prior  <= s4_prior;

      s6_prod   <= prod1_c;
      s6_u      <= s5_u;
      s6_cand   <= s5_cand;
      s6_prior  <= s5_prior;

      s7_qest   <= qest_c;
      s7_qd     <= qd_c;
      s7_u      <= s6_u;
      s7_cand   <= s6_cand;
      s7_prior  <= s6_prior;

      s8_q      <= rem_fix ? s7_qest + QUOT_W'(1) : s7_qest;
      s8_r      <= rem_fix ? rem_adj[DW-1:0] : rem_c[DW-1:0];
      s8_cand   <= s7_cand;
      s8_prior  <= s7_prior;

      s9_mean   <= mean_c;
      s9_p999   <= p999_c;
      s9_cand   <= s8_cand;
      s9_prior  <= s8_prior;

      s10_ok    <= s9_cand && in_lim;
      s10_u2    <= num_c[BU_W-1:0];
      s10_prior <= s9_prior;

      s11_prod  <= prod2_c;
      s11_u2    <= s10_u2;
      s11_ok    <= s10_ok;
      s11_prior <= s10_prior;

      s12_q2e   <= q2e_c;
      s12_qk    <= qk_c;
      s12_u2    <= s11_u2;
      s12_ok    <= s11_ok;
      s12_prior <= s11_prior;

      offset_valid <= s12_ok;
      new_offset   <= s12_ok ? $signed(blend_c[OFFSET_W-1:0]) : s12_prior;
    end
  end

  `SZOC_ASSERT_IMPL(a_minmax_order, count != '0, (hmin <= hmax) && (smin <= smax), "window min above max")
  `SZOC_ASSERT_NEXT(a_window_load, adv && stage_vld[2] && win_start, (hmax == hmin) && (smax == smin), "window start did not load statistics")
  `SZOC_ASSERT_IMPL(a_mean_rem, stage_vld[7], s8_r < DIV_WIN_V, "window remainder out of range")
  `SZOC_ASSERT_IMPL(a_blend_rem, stage_vld[11], rem2_full < 32'(2 * BLEND_DEN), "blend remainder out of range")

endmodule

`default_nettype wire

### tb/szoc_offset_checker.sv
// Checker that predicts every result item of the calibrator and compares it field by field.
`timescale 1ns / 1ps

module szoc_offset_checker
  import szoc_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  input  logic                       sample_valid,
  input  logic                       sample_ready,
  input  logic signed [SPEED_W-1:0]  vehicle_speed,
  input  logic signed [HRAD_W-1:0]   heading_rad,
  input  logic signed [STEER_W-1:0]  steer_angle,
  input  logic signed [OFFSET_W-1:0] prior_offset,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic                       offset_valid,
  input  logic signed [OFFSET_W-1:0] new_offset,
  output int                         fail_count,
  output int                         outstanding
);

  localparam longint DEG_PER_RAD_Q16 = 58671;
  localparam longint HALF_Q16 = 32768;
  localparam longint ONE_Q16 = 65536;
  localparam longint OLD_WEIGHT = 999;
  localparam longint WEIGHT_SUM = 1000;

  typedef struct packed {
    logic                       valid;
    logic signed [OFFSET_W-1:0] offset;
  } offset_update_t;

  offset_update_t pending_updates[$];
  int mismatches = 0;

  logic [MIN_SPEED_W-1:0] min_speed;
  logic [HSPREAD_W-1:0]   head_spread_limit;
  logic [SSPREAD_W-1:0]   steer_spread_limit;
  logic [OLIMIT_W-1:0]    offset_limit;

  logic [6:0] win_count;
  longint     steer_total;
  longint     head_hi;
  longint     head_lo;
  longint     steer_hi;
  longint     steer_lo;

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Advances the window statistics by one sample and returns the offset update it yields.
  function automatic offset_update_t next_update(logic signed [SPEED_W-1:0] speed,
                                                 logic signed [HRAD_W-1:0] hrad,
                                                 logic signed [STEER_W-1:0] steer,
                                                 logic signed [OFFSET_W-1:0] prior);
    longint hdeg;
    longint mean;
    longint lim;
    longint blended;
    offset_update_t upd;
    hdeg = floor_quot(longint'(hrad) * DEG_PER_RAD_Q16 + HALF_Q16, ONE_Q16);
    upd.valid = 1'b0;
    upd.offset = prior;
    if (win_count == 0) begin
      head_hi = hdeg;
      head_lo = hdeg;
      steer_hi = longint'(steer);
      steer_lo = longint'(steer);
      steer_total = 0;
    end else begin
      if (hdeg > head_hi) head_hi = hdeg;
      if (hdeg < head_lo) head_lo = hdeg;
      if (longint'(steer) > steer_hi) steer_hi = longint'(steer);
      if (longint'(steer) < steer_lo) steer_lo = longint'(steer);
    end
    steer_total = steer_total + longint'(steer);
    win_count = win_count + 7'd1;
    if (win_count >= WINDOW || win_count == 0) begin
      win_count = '0;
      lim = longint'(offset_limit);
      if (longint'(speed) > longint'(min_speed) &&
          head_hi - head_lo < longint'(head_spread_limit) &&
          steer_hi - steer_lo < longint'(steer_spread_limit)) begin
        mean = floor_quot(steer_total * 512 + WINDOW, 2 * WINDOW);
        if (mean <= lim && mean >= -lim) begin
          blended = floor_quot(2 * (mean + OLD_WEIGHT * longint'(prior)) + WEIGHT_SUM,
                               2 * WEIGHT_SUM);
          upd.valid = 1'b1;
          upd.offset = blended[OFFSET_W-1:0];
        end
      end
    end
    return upd;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    offset_update_t want;
    if (rst) begin
      pending_updates.delete();
      min_speed = 15'd2560;
      head_spread_limit = 16'd205;
      steer_spread_limit = 16'd256;
      offset_limit = 20'd393216;
      win_count = '0;
      steer_total = 0;
      head_hi = 0;
      head_lo = 0;
      steer_hi = 0;
      steer_lo = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MIN_SPEED:      min_speed = pwdata[MIN_SPEED_W-1:0];
          REG_HEADING_SPREAD: head_spread_limit = pwdata[HSPREAD_W-1:0];
          REG_STEER_SPREAD:   steer_spread_limit = pwdata[SSPREAD_W-1:0];
          REG_OFFSET_LIMIT:   offset_limit = pwdata[OLIMIT_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (pending_updates.size() == 0) begin
          report_mismatch("unexpected result item, new_offset", new_offset, 0);
        end else begin
          want = pending_updates.pop_front();
          if (offset_valid !== want.valid) begin
            report_mismatch("offset_valid", offset_valid, want.valid);
          end
          if (new_offset !== want.offset) begin
            report_mismatch("new_offset", new_offset, want.offset);
          end
        end
      end
      if (sample_valid && sample_ready) begin
        pending_updates.push_back(next_update(vehicle_speed, heading_rad, steer_angle,
                                              prior_offset));
      end
    end
    fail_count <= mismatches;
    outstanding <= pending_updates.size();
  end

endmodule

### tb/testbench.sv
// Top of the calibrator testbench: clock, reset, register setup, sample stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import szoc_pkg::*;

  localparam int WINDOW = WINDOW_DEFAULT;
  localparam int PHASES = 7;
  localparam int WINDOWS_PER_PHASE = 2;
  localparam int MAX_IDLE = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 3000;
  localparam int NUM_KINDS = 8;
  localparam int EXTREME_ITEMS = 9;

  typedef enum int {
    WIN_GOOD,
    WIN_MEAN_AT_LIMIT,
    WIN_MEAN_PAST_LIMIT,
    WIN_MEAN_AT_NEG_LIMIT,
    WIN_STEER_SPREAD_EDGE,
    WIN_HEAD_SPREAD_EDGE,
    WIN_SPEED_EDGE,
    WIN_NOISE
  } window_kind_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SPEED_W-1:0]  vehicle_speed = '0;
  logic signed [HRAD_W-1:0]   heading_rad = '0;
  logic signed [STEER_W-1:0]  steer_angle = '0;
  logic signed [OFFSET_W-1:0] prior_offset = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic                       offset_valid;
  logic signed [OFFSET_W-1:0] new_offset;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit sender_steady = 1'b0;
  bit hold_off_request = 1'b0;

  int cfg_min_speed = 2560;
  int cfg_head_spread = 205;
  int cfg_steer_spread = 256;
  int cfg_offset_limit = 393216;

  steering_zero_offset_calibrator #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .vehicle_speed(vehicle_speed),
    .heading_rad(heading_rad),
    .steer_angle(steer_angle),
    .prior_offset(prior_offset),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .offset_valid(offset_valid),
    .new_offset(new_offset)
  );

  szoc_offset_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .vehicle_speed(vehicle_speed),
    .heading_rad(heading_rad),
    .steer_angle(steer_angle),
    .prior_offset(prior_offset),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .offset_valid(offset_valid),
    .new_offset(new_offset),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("[steering_zero_offset_calibrator] ERROR");
      $finish;
    end
  end

  function automatic int draw_gap(bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits above each register's width carry junk that the block must drop.
  task automatic set_limits(int speed_floor, int head_lim, int steer_lim, int mean_lim);
    write_reg(REG_MIN_SPEED, {17'($urandom), 15'(speed_floor)});
    write_reg(REG_HEADING_SPREAD, {16'($urandom), 16'(head_lim)});
    write_reg(REG_STEER_SPREAD, {16'($urandom), 16'(steer_lim)});
    write_reg(REG_OFFSET_LIMIT, {12'($urandom), 20'(mean_lim)});
    cfg_min_speed = speed_floor;
    cfg_head_spread = head_lim;
    cfg_steer_spread = steer_lim;
    cfg_offset_limit = mean_lim;
  endtask

  task automatic send_sample(logic [SPEED_W-1:0] spd, logic [HRAD_W-1:0] hr,
                             logic [STEER_W-1:0] st, logic [OFFSET_W-1:0] pr);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
    gap = draw_gap(sender_steady);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    vehicle_speed <= spd;
    heading_rad <= hr;
    steer_angle <= st;
    prior_offset <= pr;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends the rest of one window, shaped so that its closing sample hits the chosen case.
  task automatic run_window(window_kind_t kind, int first);
    int base;
    int spread;
    int head0;
    int span;
    int last_speed;
    int quot;
    int rem;
    longint target;
    longint total;
    bit full_prior;
    logic [SPEED_W-1:0] spd;
    logic [HRAD_W-1:0] hr;
    logic [STEER_W-1:0] st;
    logic [OFFSET_W-1:0] pr;
    base = int'($urandom_range(0, 3000)) - 1500;
    spread = $urandom_range(0, (cfg_steer_spread > 3000) ? 3000 :
                               (cfg_steer_spread > 0) ? cfg_steer_spread - 1 : 0);
    head0 = int'($urandom_range(0, 600000)) - 300000;
    span = $urandom_range(0, (cfg_head_spread > 4000) ? 4000 : cfg_head_spread);
    last_speed = cfg_min_speed + int'($urandom_range(1, 2000));
    full_prior = ($urandom_range(0, 3) == 0);
    quot = 0;
    rem = 0;
    case (kind)
      WIN_MEAN_AT_LIMIT, WIN_MEAN_PAST_LIMIT, WIN_MEAN_AT_NEG_LIMIT: begin
        target = (kind == WIN_MEAN_AT_LIMIT) ? longint'(cfg_offset_limit) :
                 (kind == WIN_MEAN_PAST_LIMIT) ? longint'(cfg_offset_limit) + 1 :
                 -longint'(cfg_offset_limit);
        // Smallest steering sum whose rounded window mean reaches the target.
        total = 2 * WINDOW * target - WINDOW;
        total = (total >= 0) ? (total + 511) / 512 : -((-total) / 512);
        quot = total / WINDOW;
        rem = total % WINDOW;
        spread = 0;
        span = 0;
      end
      WIN_STEER_SPREAD_EDGE: begin
        spread = cfg_steer_spread - int'($urandom_range(0, 1));
        if (spread < 0) spread = 0;
        base = int'($urandom_range(0, 2000)) - 1000 - spread / 2;
        span = 0;
      end
      WIN_HEAD_SPREAD_EDGE: begin
        span = cfg_head_spread * 1117 / 1000 + int'($urandom_range(0, 2)) - 1;
        if (span < 0) span = 0;
        spread = 0;
      end
      WIN_SPEED_EDGE: last_speed = cfg_min_speed + int'($urandom_range(0, 1));
      default: ;
    endcase
    for (int pos = first; pos < WINDOW; pos++) begin
      if (kind == WIN_NOISE) begin
        spd = $urandom;
        hr = $urandom;
        st = $urandom;
        pr = $urandom;
      end else begin
        spd = (pos == WINDOW - 1) ? last_speed : $urandom;
        hr = head0 + ((pos == 0) ? 0 : (pos == 1) ? span : int'($urandom_range(0, span)));
        if (kind == WIN_MEAN_AT_LIMIT || kind == WIN_MEAN_PAST_LIMIT ||
            kind == WIN_MEAN_AT_NEG_LIMIT) begin
          st = quot + ((pos < rem) ? 1 : (pos < -rem) ? -1 : 0);
        end else begin
          st = base + ((pos == 0) ? 0 : (pos == 1) ? spread :
                       int'($urandom_range(0, spread)));
        end
        pr = full_prior ? $urandom : int'($urandom_range(0, 800000)) - 400000;
      end
      send_sample(spd, hr, st, pr);
    end
  endtask

  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = hold_off_request ? HOLD_OFF_CYCLES : draw_gap(steady);
      hold_off_request = 1'b0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin : stimulus
    int kinds_used;
    int pick;
    window_kind_t kind;
    kinds_used = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: set_limits(0, 65535, 65535, 1048575);
          2: set_limits(32767, 0, 0, 0);
          3: set_limits(2560, 205, 256, 0);
          default: set_limits(($urandom_range(0, 1) == 0) ? $urandom_range(0, 6000) :
                                                            $urandom_range(0, 32767),
                              $urandom_range(1, 3000), $urandom_range(2, 3000),
                              $urandom_range(0, 1048575));
        endcase
      end
      if (phase == 4) hold_off_request = 1'b1;
      for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
        if (phase == 0 && w == 0) begin
          send_sample(16'h7FFF, 20'h7FFFF, 19'h3FFFF, 21'h0FFFFF);
          send_sample(16'h8000, 20'h80000, 19'h40000, 21'h100000);
          send_sample(16'h0000, 20'h00000, 19'h00000, 21'h000000);
          send_sample(16'hFFFF, 20'hFFFFF, 19'h7FFFF, 21'h1FFFFF);
          send_sample(16384, 411775, 204800, 1048575);
          send_sample(-16384, -411775, -204800, -1048576);
          send_sample(16'h0001, 20'h00001, 19'h00001, 21'h000001);
          send_sample(16'h5555, 20'hAAAAA, 19'h2AAAA, 21'h0AAAAA);
          send_sample(16'hAAAA, 20'h55555, 19'h55555, 21'h155555);
          run_window(WIN_NOISE, EXTREME_ITEMS);
        end else begin
          pick = $urandom_range(0, 2 * NUM_KINDS - 1);
          kind = (kinds_used < NUM_KINDS) ? window_kind_t'(kinds_used) :
                 (pick < NUM_KINDS) ? window_kind_t'(pick) : WIN_GOOD;
          kinds_used++;
          run_window(kind, 0);
        end
      end
    end
    drain();
    if (fail_count == 0 && outstanding == 0) begin
      $display("[steering_zero_offset_calibrator] OK");
    end else begin
      $display("[steering_zero_offset_calibrator] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/szoc_pkg.sv
rtl/steering_zero_offset_calibrator.sv
tb/szoc_offset_checker.sv
tb/testbench.sv
